>>> hdl/vte_pkg.sv
// Package for the vertex transform engine: action codes, register indexes,
// command and result records for the front, back and top. No dependencies.
`timescale 1ns / 1ps
package vte_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_MODEL = 2'd0,
    ACT_LOAD_PROJ  = 2'd1,
    ACT_SCREEN     = 2'd2,
    ACT_CLIP       = 2'd3
  } action_t;

  localparam logic [2:0] REG_SELECTED_SLOT = 3'd0;
  localparam logic [2:0] REG_VIEW_SCALE_X  = 3'd1;
  localparam logic [2:0] REG_VIEW_SCALE_Y  = 3'd2;
  localparam logic [2:0] REG_VIEW_OFFSET_X = 3'd3;
  localparam logic [2:0] REG_VIEW_OFFSET_Y = 3'd4;

  // Vertex request handed from the front part to the back part.
  typedef struct packed {
    logic               is_clip;
    logic        [2:0]  sel;
    logic               recompute;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic        [31:0] color;
    logic signed [31:0] tex_s;
    logic signed [31:0] tex_t;
  } vert_cmd_t;

  typedef struct packed {
    logic               is_clip;
    logic               accepted;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_w;
    logic        [31:0] color_out;
    logic signed [31:0] tex_s_out;
    logic signed [31:0] tex_t_out;
  } vert_res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAT_RD, ST_MAT_MUL, ST_MAT_ACC, ST_XFORM, ST_XSUM,
    ST_DIV, ST_NDC, ST_VIEW, ST_DONE
  } back_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

>>> hdl/vte_stream_if.sv
// Valid/ready stream interface carrying one payload type.
// Depends on nothing; the payload type is a parameter.
`timescale 1ns / 1ps
interface vte_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/vte_in_if.sv
// Input channel of the vertex transform engine: handshake and input fields.
// Depends on nothing.
`timescale 1ns / 1ps
interface vte_in_if ();
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic        [2:0]  load_slot;
  logic        [3:0]  load_index;
  logic signed [31:0] load_value;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic        [31:0] color_rgba;
  logic signed [31:0] tex_s;
  logic signed [31:0] tex_t;
  modport source (output valid, action, load_slot, load_index, load_value, pos_x, pos_y,
                  pos_z, color_rgba, tex_s, tex_t, input ready);
  modport sink (input valid, action, load_slot, load_index, load_value, pos_x, pos_y,
                pos_z, color_rgba, tex_s, tex_t, output ready);
endinterface

>>> hdl/vte_out_if.sv
// Output channel of the vertex transform engine: handshake and result fields.
// Depends on nothing.
`timescale 1ns / 1ps
interface vte_out_if ();
  logic               valid;
  logic               ready;
  logic               is_clip;
  logic               accepted;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic signed [31:0] res_w;
  logic        [31:0] color_out;
  logic signed [31:0] tex_s_out;
  logic signed [31:0] tex_t_out;
  modport source (output valid, is_clip, accepted, res_x, res_y, res_z, res_w, color_out,
                  tex_s_out, tex_t_out, input ready);
  modport sink (input valid, is_clip, accepted, res_x, res_y, res_z, res_w, color_out,
                tex_s_out, tex_t_out, output ready);
endinterface

>>> hdl/vte_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module vte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/vte_front.sv
// Front part: accepts items, writes matrix loads, tracks the cache state and
// queues vertex requests. Depends on vte_pkg, vte_in_if, vte_stream_if.
`timescale 1ns / 1ps
module vte_front import vte_pkg::*; #(
  parameter int MATRIX_SLOTS = 8,
  parameter int SLOT_W = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  vte_in_if.sink                  in_ch,
  input  logic [2:0]              selected_slot,
  output logic                    model_we,
  output logic [SLOT_W+3:0]       model_waddr,
  output logic                    proj_we,
  output logic [3:0]              proj_waddr,
  output logic signed [31:0]      load_data,
  vte_stream_if.source            cmd
);
  localparam int QD = 2;

  logic        valid_c;
  logic        last_sel_dirty;
  logic [2:0]  last_selected;
  logic [2:0]  sel_eff;
  logic        acc;
  logic        is_vert;
  vert_cmd_t   q [QD];
  logic [1:0]  cnt;
  logic        rd_ptr, wr_ptr;
  logic        push, pop;
  vert_cmd_t   new_cmd;

  assign sel_eff = (32'(selected_slot) >= MATRIX_SLOTS) ? 3'(MATRIX_SLOTS - 1) : selected_slot;
  assign is_vert = in_ch.action == ACT_SCREEN || in_ch.action == ACT_CLIP;
  assign in_ch.ready = cnt != 2'(QD);
  assign acc = in_ch.valid && in_ch.ready;
  assign push = acc && is_vert;
  assign pop = cmd.valid && cmd.ready;

  assign model_we = acc && in_ch.action == ACT_LOAD_MODEL && 32'(in_ch.load_slot) < MATRIX_SLOTS;
  assign model_waddr = {in_ch.load_slot[SLOT_W-1:0], in_ch.load_index};
  assign proj_we = acc && in_ch.action == ACT_LOAD_PROJ;
  assign proj_waddr = in_ch.load_index;
  assign load_data = in_ch.load_value;

  always_comb begin
    new_cmd.is_clip = in_ch.action == ACT_CLIP;
    new_cmd.sel = sel_eff;
    new_cmd.recompute = !valid_c || sel_eff != last_selected;
    new_cmd.pos_x = in_ch.pos_x;
    new_cmd.pos_y = in_ch.pos_y;
    new_cmd.pos_z = in_ch.pos_z;
    new_cmd.color = in_ch.color_rgba;
    new_cmd.tex_s = in_ch.tex_s;
    new_cmd.tex_t = in_ch.tex_t;
  end

  // Loads and vertices stay in order: loads hit the RAM only once the queue
  // has drained, since the back part reads matrices while working.
  assign last_sel_dirty = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_c <= 1'b1;
      last_selected <= '0;
      cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (model_we || proj_we) valid_c <= 1'b0;
      if (push) begin
        valid_c <= 1'b1;
        last_selected <= sel_eff;
        wr_ptr <= !wr_ptr;
      end
      if (pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop) + 2'(last_sel_dirty);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= new_cmd;
  end

  assign cmd.valid = cnt != '0;
  assign cmd.data = q[rd_ptr];
endmodule

>>> hdl/vte_back.sv
// Back part: recomputes the cached product when asked, transforms the vertex
// and if screen divides by w, applies viewport. Uses vte_pkg, vte_stream_if.
`timescale 1ns / 1ps
module vte_back import vte_pkg::*; #(
  parameter int SLOT_W = 3,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  vte_stream_if.sink         cmd,
  output logic [SLOT_W+3:0]  model_raddr,
  input  logic signed [31:0] model_rdata,
  output logic [3:0]         proj_raddr,
  input  logic signed [31:0] proj_rdata,
  input  logic signed [31:0] view_scale_x,
  input  logic signed [31:0] view_scale_y,
  input  logic signed [31:0] view_offset_x,
  input  logic signed [31:0] view_offset_y,
  vte_stream_if.source       res
);
  localparam logic [31:0] ONE = 32'(64'(1) << FRAC_BITS);

  back_state_t        state, state_next;
  vert_cmd_t          cur;
  logic signed [31:0] comb [16];
  logic [5:0]         step;
  logic signed [31:0] a_elem, b_elem;
  logic signed [63:0] prod;
  logic signed [71:0] hi_acc, lo_acc;
  logic signed [31:0] c [4];
  logic signed [63:0] pterm [4];
  logic signed [71:0] csum;
  logic [1:0]         col;
  // divider
  logic [63:0]        rem;
  logic [31:0]        divisor;
  logic [32:0]        quo;
  logic [5:0]         dcnt;
  logic signed [31:0] oow;
  logic signed [31:0] nx, ny, nz;
  logic signed [63:0] mx, my;
  logic               out_full;
  vert_res_t          out_r;

  assign cmd.ready = state == ST_IDLE;
  assign res.valid = out_full;
  assign res.data = out_r;

  // step walks i,j,k for the product: element (i,j) term k.
  assign model_raddr = {cur.sel[SLOT_W-1:0], step[5:4], step[1:0]};
  assign proj_raddr = {step[1:0], step[3:2]};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (cmd.valid) state_next = cmd.data.recompute ? ST_MAT_RD : ST_XFORM;
      ST_MAT_RD:  state_next = ST_MAT_MUL;
      ST_MAT_MUL: state_next = ST_MAT_ACC;
      ST_MAT_ACC: state_next = (step[1:0] == 2'd3 && step[5:2] == 4'hf) ? ST_XFORM : ST_MAT_RD;
      ST_XFORM:   state_next = ST_XSUM;
      ST_XSUM:    if (col == 2'd3) state_next = cur.is_clip ? ST_DONE : ST_DIV;
                  else state_next = ST_XFORM;
      ST_DIV:     if (c[3] <= 0) state_next = ST_DONE;
                  else if (dcnt == 6'd0) state_next = ST_NDC;
      ST_NDC:     if (col == 2'd2) state_next = ST_VIEW;
      ST_VIEW:    if (col == 2'd1) state_next = ST_DONE;
      ST_DONE:    if (!out_full || res.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      for (int i = 0; i < 16; i++) comb[i] <= (i % 5 == 0) ? ONE : 32'sd0;
    end else begin
      if (res.valid && res.ready && state != ST_DONE) out_full <= 1'b0;
      case (state)
        ST_IDLE: begin
          cur <= cmd.data;
          step <= '0;
          col <= '0;
          hi_acc <= '0;
          lo_acc <= '0;
        end
        ST_MAT_RD: ;
        ST_MAT_MUL: prod <= 64'(model_rdata) * 64'(proj_rdata);
        ST_MAT_ACC: begin
          if (step[1:0] == 2'd3) begin
            comb[step[5:2]] <= sat32(hi_acc + 72'(prod >>> FRAC_BITS) +
              72'((lo_acc + 72'(prod & 64'(ONE - 1))) >>> FRAC_BITS));
            hi_acc <= '0;
            lo_acc <= '0;
          end else begin
            hi_acc <= hi_acc + 72'(prod >>> FRAC_BITS);
            lo_acc <= lo_acc + 72'(prod & 64'(ONE - 1));
          end
          step <= step + 6'd1;
        end
        ST_XFORM: begin
          pterm[0] <= 64'(cur.pos_x) * 64'(comb[{2'd0, col}]);
          pterm[1] <= 64'(cur.pos_y) * 64'(comb[{2'd1, col}]);
          pterm[2] <= 64'(cur.pos_z) * 64'(comb[{2'd2, col}]);
          pterm[3] <= 64'(comb[{2'd3, col}]);
        end
        ST_XSUM: begin
          c[col] <= sat32(72'(pterm[0]) + 72'(pterm[1]) + 72'(pterm[2]) + 72'(pterm[3]));
          col <= col + 2'd1;
          rem <= 64'(1) << (2 * FRAC_BITS);
          quo <= '0;
          dcnt <= 6'd33;
        end
        ST_DIV: begin
          // restoring division, one quotient bit a cycle
          divisor <= c[3];
          if (dcnt != 6'd33 && dcnt != 6'd0) begin
            if ((rem >> (dcnt - 6'd1)) >= 64'(divisor)) begin
              rem <= rem - (64'(divisor) << (dcnt - 6'd1));
              quo <= quo | (33'(1) << (dcnt - 6'd1));
            end
          end
          if (dcnt != 6'd0) dcnt <= dcnt - 6'd1;
          if (dcnt == 6'd1 || (dcnt == 6'd0)) begin
            oow <= sat32(72'(quo | ((dcnt == 6'd1 && (rem >= 64'(divisor))) ? 33'd1 : 33'd0)));
          end
          col <= '0;
        end
        ST_NDC: begin
          case (col)
            2'd0: nx <= sat32(72'((64'(c[0]) * 64'(oow)) >>> FRAC_BITS));
            2'd1: ny <= sat32(72'((64'(c[1]) * 64'(oow)) >>> FRAC_BITS));
            default: nz <= sat32(72'((64'(c[2]) * 64'(oow)) >>> FRAC_BITS));
          endcase
          col <= (col == 2'd2) ? 2'd0 : col + 2'd1;
          if (col == 2'd2) begin
            mx <= 64'(nx) * 64'(view_scale_x);
            my <= 64'(ny) * 64'(view_scale_y);
          end
        end
        ST_VIEW: begin
          if (col == 2'd0) begin
            mx <= 64'(nx) * 64'(view_scale_x);
            my <= 64'(ny) * 64'(view_scale_y);
          end
          col <= col + 2'd1;
        end
        ST_DONE: if (!out_full || res.ready) begin
          out_full <= 1'b1;
          out_r.is_clip <= cur.is_clip;
          out_r.color_out <= cur.color;
          if (cur.is_clip) begin
            out_r.accepted <= 1'b1;
            out_r.res_x <= c[0];
            out_r.res_y <= c[1];
            out_r.res_z <= c[2];
            out_r.res_w <= c[3];
            out_r.tex_s_out <= cur.tex_s;
            out_r.tex_t_out <= cur.tex_t;
          end else begin
            out_r.tex_s_out <= '0;
            out_r.tex_t_out <= '0;
            if (c[3] <= 0) begin
              out_r.accepted <= 1'b0;
              out_r.res_x <= '0;
              out_r.res_y <= '0;
              out_r.res_z <= '0;
              out_r.res_w <= '0;
            end else begin
              out_r.accepted <= 1'b1;
              out_r.res_x <= sat32(72'(mx >>> FRAC_BITS) + 72'(view_offset_x));
              out_r.res_y <= sat32(72'(my >>> FRAC_BITS) + 72'(view_offset_y));
              out_r.res_z <= nz;
              out_r.res_w <= oow;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> hdl/vertex_transform_engine.sv
// Vertex transform engine: model/projection fixed-point transform with
// viewport mapping. Depends on vte_pkg, the channel interfaces and submodules.
`timescale 1ns / 1ps
// After reset a clearing pass writes identity into every model slot and the
// projection RAM, one element a cycle, during which input is held off. A front
// part then takes one item per cycle while its two-entry request queue has
// room: load items write the model bank or projection RAM at once and produce
// no result, vertex items are queued. The back part serves one vertex at a
// time. After a load or a change of selected_slot the first vertex costs a
// product recompute (16 elements x 4 terms, each a RAM read, a multiply and
// an accumulate through one multiplier). A clip vertex then reaches its
// result register in these steps: the back part takes it, multiplies and
// sums each of the four columns, and stores the result; a screen vertex adds
// a bit-serial reciprocal and then the divide and viewport scaling, unless w
// is not positive and the vertex is rejected. Loads wait while vertices are
// queued or the back part is busy, so matrix changes never overtake a vertex.
// Results sit in an output register; the back part holds its finished result
// until that register is free, then takes the next request.
module vertex_transform_engine import vte_pkg::*; #(
  parameter int MATRIX_SLOTS = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  vte_in_if.sink      in_ch,
  vte_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // Slot fields are three bits wide, so at most eight slots are reachable.
  localparam int SLOT_W = (MATRIX_SLOTS > 8) ? 3 :
                          (MATRIX_SLOTS > 1) ? $clog2(MATRIX_SLOTS) : 1;
  localparam int DEPTH = (1 << SLOT_W) * 16;

  function automatic logic signed [31:0] fx(input longint v);
    return sat32(72'(v * (longint'(1) << FRAC_BITS)));
  endfunction

  logic [2:0]         selected_slot;
  logic signed [31:0] view_scale_x, view_scale_y, view_offset_x, view_offset_y;
  logic               cfg_wr;
  logic               model_we, proj_we;
  logic [SLOT_W+3:0]  model_waddr, model_raddr;
  logic [3:0]         proj_waddr, proj_raddr;
  logic signed [31:0] load_data, model_rdata, proj_rdata;
  logic               model_we_g, proj_we_g;
  logic               init_busy;
  logic [SLOT_W+4:0]  init_cnt;
  logic [SLOT_W+3:0]  ram_waddr;
  logic [31:0]        ram_wdata;
  logic               gate_ready;

  vte_stream_if #(.T(vert_cmd_t)) cmd ();
  vte_stream_if #(.T(vert_res_t)) res ();
  vte_in_if in_g ();

  // Register file: written on the APB access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_slot <= '0;
      view_scale_x <= fx(320);
      view_scale_y <= fx(-240);
      view_offset_x <= fx(320);
      view_offset_y <= fx(240);
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_SELECTED_SLOT: selected_slot <= pwdata[2:0];
        REG_VIEW_SCALE_X:  view_scale_x <= pwdata;
        REG_VIEW_SCALE_Y:  view_scale_y <= pwdata;
        REG_VIEW_OFFSET_X: view_offset_x <= pwdata;
        REG_VIEW_OFFSET_Y: view_offset_y <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SELECTED_SLOT: prdata = {29'd0, selected_slot};
      REG_VIEW_SCALE_X:  prdata = view_scale_x;
      REG_VIEW_SCALE_Y:  prdata = view_scale_y;
      REG_VIEW_OFFSET_X: prdata = view_offset_x;
      REG_VIEW_OFFSET_Y: prdata = view_offset_y;
      default:           prdata = '0;
    endcase
  end

  // Clearing pass after reset: write identity into every model slot; hold
  // input off until it finishes. Hold loads while vertices are queued or in
  // flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_busy <= 1'b1;
      init_cnt <= '0;
    end else if (init_busy) begin
      init_cnt <= init_cnt + (SLOT_W+5)'(1);
      if (init_cnt == (SLOT_W+5)'(DEPTH - 1)) init_busy <= 1'b0;
    end
  end

  logic load_blocked;
  assign load_blocked = (in_ch.action == ACT_LOAD_MODEL || in_ch.action == ACT_LOAD_PROJ)
                        && (cmd.valid || !cmd.ready);

  assign in_g.valid = in_ch.valid && !init_busy && !load_blocked;
  assign in_ch.ready = gate_ready && !init_busy && !load_blocked;
  assign gate_ready = in_g.ready;
  assign in_g.action = in_ch.action;
  assign in_g.load_slot = in_ch.load_slot;
  assign in_g.load_index = in_ch.load_index;
  assign in_g.load_value = in_ch.load_value;
  assign in_g.pos_x = in_ch.pos_x;
  assign in_g.pos_y = in_ch.pos_y;
  assign in_g.pos_z = in_ch.pos_z;
  assign in_g.color_rgba = in_ch.color_rgba;
  assign in_g.tex_s = in_ch.tex_s;
  assign in_g.tex_t = in_ch.tex_t;

  vte_front #(.MATRIX_SLOTS(MATRIX_SLOTS), .SLOT_W(SLOT_W)) u_front (
    .clk, .rst, .in_ch(in_g), .selected_slot, .model_we, .model_waddr,
    .proj_we, .proj_waddr, .load_data, .cmd(cmd.source)
  );

  // Diagonal elements of a 4x4 matrix sit at positions 0, 5, 10 and 15.
  assign model_we_g = init_busy || model_we;
  assign ram_waddr = init_busy ? init_cnt[SLOT_W+3:0] : model_waddr;
  assign ram_wdata = init_busy ? ((init_cnt[3:0] inside {4'd0, 4'd5, 4'd10, 4'd15})
                                  ? 32'(64'(1) << FRAC_BITS) : '0)
                               : load_data;

  vte_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_model_ram (
    .clk, .we(model_we_g), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(model_raddr), .rdata(model_rdata)
  );

  // Projection RAM is tiny; hold it in the same generic RAM, identity filled
  // by the first sixteen elements of the clearing pass.
  assign proj_we_g = (init_busy && init_cnt < (SLOT_W+5)'(16)) || proj_we;
  vte_ram #(.WIDTH(32), .DEPTH(16)) u_proj_ram (
    .clk, .we(proj_we_g), .waddr(init_busy ? init_cnt[3:0] : proj_waddr),
    .wdata(init_busy ? ram_wdata : load_data), .raddr(proj_raddr), .rdata(proj_rdata)
  );

  vte_back #(.SLOT_W(SLOT_W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .cmd(cmd.sink), .model_raddr, .model_rdata, .proj_raddr, .proj_rdata,
    .view_scale_x, .view_scale_y, .view_offset_x, .view_offset_y, .res(res.source)
  );

  assign out_ch.valid = res.valid;
  assign res.ready = out_ch.ready;
  assign out_ch.is_clip = res.data.is_clip;
  assign out_ch.accepted = res.data.accepted;
  assign out_ch.res_x = res.data.res_x;
  assign out_ch.res_y = res.data.res_y;
  assign out_ch.res_z = res.data.res_z;
  assign out_ch.res_w = res.data.res_w;
  assign out_ch.color_out = res.data.color_out;
  assign out_ch.tex_s_out = res.data.tex_s_out;
  assign out_ch.tex_t_out = res.data.tex_t_out;
endmodule

>>> hdl/vte_checker.sv
// Port-level checks for the vertex transform engine, bound to the top level.
// Depends on vte_pkg.
`timescale 1ns / 1ps
module vte_checker import vte_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_clip,
  input logic        accepted,
  input logic [31:0] res_x,
  input logic [31:0] tex_s_out,
  input logic        pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_x)) else $error("result dropped");
  a_clip_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_clip |-> accepted) else $error("clip result rejected");
  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> res_x == '0 && !is_clip) else $error("rejected not zero");
  a_scr_tex: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_clip |-> tex_s_out == '0) else $error("screen tex not zero");
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind vertex_transform_engine vte_checker u_chk (
  .clk, .rst, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .is_clip(out_ch.is_clip), .accepted(out_ch.accepted), .res_x(out_ch.res_x),
  .tex_s_out(out_ch.tex_s_out), .pready
);

>>> verif/testbench.sv
// Self-checking testbench for vertex_transform_engine: random and directed
// requests through the stream channels and APB register writes.
// Depends on vte_pkg, vte_in_if, vte_out_if and the engine itself.
`timescale 1ns / 1ps
module testbench;
  import vte_pkg::*;

  localparam int SLOTS        = 8;
  localparam int FRAC         = 16;
  localparam int SEGMENTS     = 8;
  localparam int SEG_REQUESTS = 200;
  localparam int DRAIN_CYCLES = 150;   // extra wait once every result is back
  localparam int STALL_LIMIT  = 5000;  // cycles with no transfer anywhere

  typedef struct {
    action_t            act;
    logic        [2:0]  slot;
    logic        [3:0]  index;
    logic signed [31:0] value;
    logic signed [15:0] px, py, pz;
    logic        [31:0] color;
    logic signed [31:0] ts, tt;
  } xform_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vte_in_if  in_ch ();
  vte_out_if out_ch ();

  vertex_transform_engine uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow state of the engine: matrices and viewport registers.
  logic signed [31:0] shadow_bank [SLOTS*16];
  logic signed [31:0] shadow_proj [16];
  logic        [2:0]  shadow_sel;
  logic signed [31:0] shadow_scale_x, shadow_scale_y, shadow_off_x, shadow_off_y;

  xform_req_t pending_reqs [$];
  vert_res_t  expected_verts [$];
  xform_req_t held_req;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int n_loads = 0, n_clip = 0, n_screen = 0, n_rejected = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp a wide value to the signed 32-bit range.
  function automatic logic signed [31:0] clamp_word(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Expected result of one vertex: product of the selected model matrix and
  // the projection, row vector times product, then either the clip result or
  // reciprocal, divide and viewport. The product is always rebuilt from the
  // shadow state, which gives the same values as the engine's cached copy.
  function automatic vert_res_t transform_vertex(input xform_req_t r);
    vert_res_t          res;
    logic signed [31:0] comb [16];
    longint             hi, lo, p, c [4], oow, nx, ny;
    int                 base;
    base = int'(shadow_sel) * 16;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        hi = 0;
        lo = 0;
        for (int k = 0; k < 4; k++) begin
          p  = longint'(shadow_bank[base + i*4 + k]) * longint'(shadow_proj[k*4 + j]);
          hi += p >>> FRAC;
          lo += p & ((64'sd1 << FRAC) - 1);
        end
        comb[i*4 + j] = clamp_word(hi + (lo >>> FRAC));
      end
    end
    for (int j = 0; j < 4; j++)
      c[j] = clamp_word(longint'(r.px) * comb[j] + longint'(r.py) * comb[4+j]
                        + longint'(r.pz) * comb[8+j] + longint'(comb[12+j]));
    res = '0;
    res.color_out = r.color;
    if (r.act == ACT_CLIP) begin
      res.is_clip   = 1'b1;
      res.accepted  = 1'b1;
      res.res_x     = c[0][31:0];
      res.res_y     = c[1][31:0];
      res.res_z     = c[2][31:0];
      res.res_w     = c[3][31:0];
      res.tex_s_out = r.ts;
      res.tex_t_out = r.tt;
    end else if (c[3] > 0) begin
      oow = clamp_word((64'sd1 << (2*FRAC)) / c[3]);
      nx  = clamp_word((c[0] * oow) >>> FRAC);
      ny  = clamp_word((c[1] * oow) >>> FRAC);
      res.accepted = 1'b1;
      res.res_x = clamp_word(((nx * shadow_scale_x) >>> FRAC) + shadow_off_x);
      res.res_y = clamp_word(((ny * shadow_scale_y) >>> FRAC) + shadow_off_y);
      res.res_z = clamp_word((c[2] * oow) >>> FRAC);
      res.res_w = oow[31:0];
    end
    return res;
  endfunction

  // Apply an accepted request to the shadow state or queue its result.
  task automatic absorb_request(input xform_req_t r);
    vert_res_t v;
    case (r.act)
      ACT_LOAD_MODEL: begin
        shadow_bank[int'(r.slot)*16 + int'(r.index)] = r.value;
        n_loads++;
      end
      ACT_LOAD_PROJ: begin
        shadow_proj[r.index] = r.value;
        n_loads++;
      end
      default: begin
        v = transform_vertex(r);
        expected_verts.push_back(v);
        if (r.act == ACT_CLIP) n_clip++;
        else begin
          n_screen++;
          if (!v.accepted) n_rejected++;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t: %s mismatch: got %h, want %h", $realtime, field, got, want);
  endtask

  // Driver: hold a request until taken, idle only between requests.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) absorb_request(held_req);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          held_req = pending_reqs.pop_front();
          in_ch.action     <= held_req.act;
          in_ch.load_slot  <= held_req.slot;
          in_ch.load_index <= held_req.index;
          in_ch.load_value <= held_req.value;
          in_ch.pos_x      <= held_req.px;
          in_ch.pos_y      <= held_req.py;
          in_ch.pos_z      <= held_req.pz;
          in_ch.color_rgba <= held_req.color;
          in_ch.tex_s      <= held_req.ts;
          in_ch.tex_t      <= held_req.tt;
          in_ch.valid      <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random and check each result against the oldest
  // expected vertex.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_verts.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected", $realtime);
        end else begin
          automatic vert_res_t w = expected_verts.pop_front();
          if (out_ch.is_clip !== w.is_clip) report_mismatch("is_clip", out_ch.is_clip, w.is_clip);
          if (out_ch.accepted !== w.accepted)
            report_mismatch("accepted", out_ch.accepted, w.accepted);
          if (out_ch.res_x !== w.res_x) report_mismatch("res_x", out_ch.res_x, w.res_x);
          if (out_ch.res_y !== w.res_y) report_mismatch("res_y", out_ch.res_y, w.res_y);
          if (out_ch.res_z !== w.res_z) report_mismatch("res_z", out_ch.res_z, w.res_z);
          if (out_ch.res_w !== w.res_w) report_mismatch("res_w", out_ch.res_w, w.res_w);
          if (out_ch.color_out !== w.color_out)
            report_mismatch("color_out", out_ch.color_out, w.color_out);
          if (out_ch.tex_s_out !== w.tex_s_out)
            report_mismatch("tex_s_out", out_ch.tex_s_out, w.tex_s_out);
          if (out_ch.tex_t_out !== w.tex_t_out)
            report_mismatch("tex_t_out", out_ch.tex_t_out, w.tex_t_out);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles in which neither channel nor the APB port moves.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_verts.size());
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // APB write: setup cycle then access cycle, register taken on the access edge.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SELECTED_SLOT: shadow_sel     = data[2:0];
      REG_VIEW_SCALE_X:  shadow_scale_x = data;
      REG_VIEW_SCALE_Y:  shadow_scale_y = data;
      REG_VIEW_OFFSET_X: shadow_off_x   = data;
      default:           shadow_off_y   = data;
    endcase
  endtask

  // Hold until every request is taken and every result is back, then wait out
  // the extra drain period as well.
  task automatic drain;
    while (pending_reqs.size() > 0 || in_ch.valid || expected_verts.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic xform_req_t load_req(input action_t a, input logic [2:0] s,
                                          input logic [3:0] i, input logic [31:0] v);
    xform_req_t r;
    r = '{act: a, slot: s, index: i, value: v, px: 16'($urandom), py: 16'($urandom),
          pz: 16'($urandom), color: $urandom, ts: $urandom, tt: $urandom};
    return r;
  endfunction

  function automatic xform_req_t vert_req(input action_t a, input logic [15:0] x,
                                          input logic [15:0] y, input logic [15:0] z);
    xform_req_t r;
    r = '{act: a, slot: 3'($urandom), index: 4'($urandom), value: $urandom,
          px: x, py: y, pz: z, color: $urandom, ts: $urandom, tt: $urandom};
    return r;
  endfunction

  // Matrix element: mostly modest 16.16 values, some near one, some raw.
  function automatic logic [31:0] pick_element;
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return 32'($urandom_range(262144) - 131072);
    if (roll < 85) return 32'($urandom_range(8192) + 61440);
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_coord;
    if ($urandom_range(99) < 80) return 16'($urandom_range(128) - 64);
    return 16'($urandom);
  endfunction

  // Random request: mostly vertices, with some model and projection loads.
  function automatic xform_req_t random_req;
    int roll;
    roll = $urandom_range(99);
    if (roll < 12)
      return load_req(ACT_LOAD_MODEL, 3'($urandom), 4'($urandom), pick_element());
    if (roll < 20)
      return load_req(ACT_LOAD_PROJ, 3'($urandom), 4'($urandom), pick_element());
    return vert_req(roll < 60 ? ACT_SCREEN : ACT_CLIP, pick_coord(), pick_coord(),
                    pick_coord());
  endfunction

  task automatic queue_directed;
    // identity transform, coordinate extremes in both modes
    pending_reqs.push_back(vert_req(ACT_CLIP, 16'h7fff, 16'h8000, 16'h0000));
    pending_reqs.push_back(vert_req(ACT_CLIP, 16'h8000, 16'h7fff, 16'hffff));
    pending_reqs.push_back(vert_req(ACT_SCREEN, 16'h0001, 16'hffff, 16'h7fff));
    pending_reqs.push_back(vert_req(ACT_SCREEN, 16'h8000, 16'h7fff, 16'h8000));
    // zero w: screen vertex rejected, clip vertex still passes
    pending_reqs.push_back(load_req(ACT_LOAD_PROJ, 3'd0, 4'd15, 32'h0000_0000));
    pending_reqs.push_back(vert_req(ACT_SCREEN, 16'h0000, 16'h0000, 16'h0000));
    pending_reqs.push_back(vert_req(ACT_CLIP, 16'h0000, 16'h0000, 16'h0000));
    // negative w rejected
    pending_reqs.push_back(load_req(ACT_LOAD_PROJ, 3'd7, 4'd15, 32'hffff_0000));
    pending_reqs.push_back(vert_req(ACT_SCREEN, 16'h0003, 16'h0005, 16'h0007));
    // tiny positive w: reciprocal and screen coordinates saturate
    pending_reqs.push_back(load_req(ACT_LOAD_PROJ, 3'd0, 4'd15, 32'h0000_0001));
    pending_reqs.push_back(vert_req(ACT_SCREEN, 16'h0100, 16'hff00, 16'h0010));
    pending_reqs.push_back(load_req(ACT_LOAD_PROJ, 3'd0, 4'd15, 32'h0001_0000));
    // element extremes: product saturates, slot and index corners
    pending_reqs.push_back(load_req(ACT_LOAD_MODEL, 3'd0, 4'd0, 32'h7fff_ffff));
    pending_reqs.push_back(load_req(ACT_LOAD_PROJ, 3'd0, 4'd0, 32'h7fff_ffff));
    pending_reqs.push_back(vert_req(ACT_CLIP, 16'h7fff, 16'h0001, 16'h0001));
    pending_reqs.push_back(load_req(ACT_LOAD_MODEL, 3'd0, 4'd1, 32'h8000_0000));
    pending_reqs.push_back(vert_req(ACT_SCREEN, 16'h0002, 16'h0000, 16'h0000));
    pending_reqs.push_back(load_req(ACT_LOAD_MODEL, 3'd7, 4'd15, 32'h8000_0000));
    pending_reqs.push_back(load_req(ACT_LOAD_MODEL, 3'd0, 4'd0, 32'h0001_0000));
    pending_reqs.push_back(load_req(ACT_LOAD_MODEL, 3'd0, 4'd1, 32'h0000_0000));
    pending_reqs.push_back(load_req(ACT_LOAD_PROJ, 3'd0, 4'd0, 32'h0001_0000));
    pending_reqs.push_back(vert_req(ACT_CLIP, 16'h0005, 16'hfffb, 16'h0009));
  endtask

  // Viewport setting per segment: reset values, extremes, zero and random.
  task automatic program_viewport(input int seg);
    logic [31:0] sx, sy, ox, oy;
    case (seg % 4)
      0: begin sx = 32'h0140_0000; sy = 32'hff10_0000; ox = 32'h0140_0000; oy = 32'h00f0_0000; end
      1: begin sx = 32'h7fff_ffff; sy = 32'h8000_0000; ox = 32'h8000_0000; oy = 32'h7fff_ffff; end
      2: begin sx = 32'h0000_0000; sy = 32'h0000_0000; ox = 32'h0000_0000; oy = 32'h0000_0000; end
      default: begin sx = $urandom; sy = $urandom; ox = $urandom; oy = $urandom; end
    endcase
    write_register(REG_SELECTED_SLOT, (seg == 1) ? 32'd7 : (seg == 2) ? 32'd0 : 32'($urandom_range(7)));
    write_register(REG_VIEW_SCALE_X, sx);
    write_register(REG_VIEW_SCALE_Y, sy);
    write_register(REG_VIEW_OFFSET_X, ox);
    write_register(REG_VIEW_OFFSET_Y, oy);
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD_MODEL;
    in_ch.load_slot = '0;
    in_ch.load_index = '0;
    in_ch.load_value = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.color_rgba = '0;
    in_ch.tex_s = '0;
    in_ch.tex_t = '0;
    out_ch.ready = 1'b0;
    // Shadow state as the engine comes out of reset: identity everywhere.
    for (int i = 0; i < SLOTS*16; i++)
      shadow_bank[i] = (i % 16 % 5 == 0) ? 32'h0001_0000 : 32'h0;
    for (int i = 0; i < 16; i++)
      shadow_proj[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
    shadow_sel = 3'd0;
    shadow_scale_x = 32'sd20971520;
    shadow_scale_y = -32'sd15728640;
    shadow_off_x = 32'sd20971520;
    shadow_off_y = 32'sd15728640;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed requests run against the reset register values.
    queue_directed();
    drain();

    // Each idling pattern gets two segments, each with its own viewport.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      program_viewport(seg);
      for (int n = 0; n < SEG_REQUESTS; n++)
        pending_reqs.push_back(random_req());
      drain();
    end

    $display("covered %0d matrix loads, %0d clip and %0d screen vertices (%0d rejected)",
             n_loads, n_clip, n_screen, n_rejected);
    $display("over %0d viewport settings and four handshake idling patterns", SEGMENTS);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/vte_pkg.sv
hdl/vte_stream_if.sv
hdl/vte_in_if.sv
hdl/vte_out_if.sv
hdl/vte_ram.sv
hdl/vte_front.sv
hdl/vte_back.sv
hdl/vertex_transform_engine.sv
hdl/vte_checker.sv
verif/testbench.sv
